// ===== sv/assert_macros.svh =====
// Assertion macros shared by the scanner modules.
// Define NO_ASSERTIONS to compile them away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// The property must hold at every rising edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// The property must never hold at a rising edge outside reset.
`define ASSERT_NEVER(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) not (prop)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_ALWAYS(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, prop)

`endif

`endif

// ===== sv/mbps_pkg.sv =====
`timescale 1ns / 1ps

package mbps_pkg;

  // Defaults for the top-level parameters.
  localparam int PATTERN_MAX_DEFAULT = 32;
  localparam int OFFSET_BITS_DEFAULT = 32;

  // Pattern bytes held by the configuration registers.
  localparam int PATTERN_BYTES_HELD = 32;

  // Configuration register indexes.
  localparam logic [2:0] REG_PATTERN_LOW      = 3'd0;
  localparam logic [2:0] REG_PATTERN_MID_LOW  = 3'd1;
  localparam logic [2:0] REG_PATTERN_MID_HIGH = 3'd2;
  localparam logic [2:0] REG_PATTERN_HIGH     = 3'd3;
  localparam logic [2:0] REG_COMPARE_MASK     = 3'd4;
  localparam logic [2:0] REG_PATTERN_LENGTH   = 3'd5;

  // One beat of the scanned byte stream.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       region_end;
  } byte_beat_t;

  // One result beat.
  typedef struct packed {
    logic        found;
    logic [31:0] match_offset;
  } result_t;

  // One configuration write beat.
  typedef struct packed {
    logic [2:0]  reg_index;
    logic [63:0] reg_data;
  } cfg_beat_t;

  // Compare control handed to each window cell.
  typedef struct packed {
    logic       care;
    logic [7:0] pattern;
  } cell_ctrl_t;

endpackage

// ===== sv/mbps_stream_if.sv =====
`timescale 1ns / 1ps

// Valid/ready channel carrying one payload per beat.
interface mbps_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== sv/mbps_cell.sv =====
`timescale 1ns / 1ps

// One window cell: holds one byte of the window, passes it on to the next
// cell when the window shifts, and compares the byte arriving at its input
// with the pattern byte that lines up with it.
module mbps_cell (
  input  logic                clk,
  input  logic                shift,
  input  logic [7:0]          in_byte,
  input  mbps_pkg::cell_ctrl_t ctrl,
  output logic [7:0]          out_byte,
  output logic                hit
);

  // Window byte, moved along the chain on every accepted beat until the region matches.
  always_ff @(posedge clk) begin
    if (shift) begin
      out_byte <= in_byte;
    end
  end

  // A wildcard or an unused position always agrees.
  assign hit = !ctrl.care || (in_byte == ctrl.pattern);

endmodule

// ===== sv/mbps_out_buf.sv =====
`timescale 1ns / 1ps

`include "assert_macros.svh"

// Two-entry result buffer: an output register and a skid register behind it,
// so that the scanner keeps taking bytes while a result waits to be taken.
module mbps_out_buf (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  mbps_pkg::result_t    push_data,
  output logic                 has_room,
  mbps_stream_if.source        result
);

  logic                 head_valid;
  logic                 skid_valid;
  logic                 head_valid_next;
  logic                 skid_valid_next;
  mbps_pkg::result_t    head;
  mbps_pkg::result_t    skid;
  logic                 pop;
  logic                 to_skid;

  assign pop      = head_valid && result.ready;
  assign has_room = !skid_valid;

  // Occupancy after this edge; a new result goes behind whatever stays.
  always_comb begin
    head_valid_next = head_valid;
    skid_valid_next = skid_valid;
    if (pop) begin
      if (skid_valid) begin
        skid_valid_next = 1'b0;
      end else begin
        head_valid_next = 1'b0;
      end
    end
    to_skid = head_valid_next;
    if (push) begin
      if (to_skid) begin
        skid_valid_next = 1'b1;
      end else begin
        head_valid_next = 1'b1;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      head_valid <= head_valid_next;
      skid_valid <= skid_valid_next;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (pop && skid_valid) begin
      head <= skid;
    end
    if (push) begin
      if (to_skid) begin
        skid <= push_data;
      end else begin
        head <= push_data;
      end
    end
  end

  assign result.valid   = head_valid;
  assign result.payload = head;

  // The skid register is only ever filled behind a held head.
  `ASSERT_ALWAYS(a_skid_behind_head, clk, rst, skid_valid |-> head_valid)
  // A waiting head that is not taken keeps its value.
  `ASSERT_ALWAYS(a_head_holds, clk, rst,
    (head_valid && !result.ready) |=> (head_valid && $stable(head)))

endmodule

// ===== sv/masked_byte_pattern_scanner.sv =====
`timescale 1ns / 1ps

`include "assert_macros.svh"

// Masked byte pattern scanner. Bytes of a region arrive one per beat on
// "bytes"; the last byte of a region carries region_end. The block reports the
// first place in the region where the last pattern_length bytes agree with the
// pattern at every position whose compare_mask bit is set (found = 1 and the
// offset of the first matched byte), or found = 0 once the region ends
// without a match; further bytes of a matched region give nothing. It takes
// one byte every clock cycle: the window is a chain of byte cells that shifts
// once per beat until the region matches, and every cell compares its byte in
// parallel, so the match decision and the offset are ready in the cycle the
// byte is accepted and the result is registered in the two-entry result buffer,
// which lets bytes keep flowing while one result waits; input stalls only
// while two results are held. Configuration registers are written through
// "cfg", which is always ready, and should be written between regions.
module masked_byte_pattern_scanner #(
  parameter int PATTERN_MAX = mbps_pkg::PATTERN_MAX_DEFAULT,
  parameter int OFFSET_BITS = mbps_pkg::OFFSET_BITS_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  mbps_stream_if.sink   bytes,
  mbps_stream_if.source result,
  mbps_stream_if.sink   cfg
);

  // Cells actually compared: no more than the pattern registers hold.
  localparam int CELLS = (PATTERN_MAX < mbps_pkg::PATTERN_BYTES_HELD) ?
                         PATTERN_MAX : mbps_pkg::PATTERN_BYTES_HELD;
  localparam logic [5:0] CELLS_LEN = 6'(CELLS);
  localparam logic [OFFSET_BITS-1:0] COUNT_MAX = {OFFSET_BITS{1'b1}};

  // Configuration registers.
  logic [63:0] pattern_word [4];
  logic [31:0] compare_mask;
  logic [5:0]  pattern_length;

  // Scan state.
  logic [OFFSET_BITS-1:0] bytes_seen;
  logic                   match_done;

  logic [7:0]             pat_byte [32];
  logic [5:0]             len_eff;
  logic [OFFSET_BITS-1:0] len_ext;
  logic [OFFSET_BITS-1:0] count_next;
  logic [OFFSET_BITS-1:0] offset;
  logic [OFFSET_BITS+31:0] offset_wide;
  logic [CELLS-1:0]       hits;
  logic [7:0]             chain [CELLS+1];
  logic                   accept;
  logic                   shift;
  logic                   match_hit;
  logic                   push;
  logic                   has_room;
  mbps_pkg::byte_beat_t   beat;
  mbps_pkg::cfg_beat_t    wr;
  mbps_pkg::result_t      res;

  assign beat      = bytes.payload;
  assign wr        = cfg.payload;
  assign cfg.ready = 1'b1;

  // Configuration writes; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int w = 0; w < 4; w++) begin
        pattern_word[w] <= '0;
      end
      compare_mask   <= '0;
      pattern_length <= 6'd1;
    end else if (cfg.valid) begin
      unique case (wr.reg_index)
        mbps_pkg::REG_PATTERN_LOW:      pattern_word[0] <= wr.reg_data;
        mbps_pkg::REG_PATTERN_MID_LOW:  pattern_word[1] <= wr.reg_data;
        mbps_pkg::REG_PATTERN_MID_HIGH: pattern_word[2] <= wr.reg_data;
        mbps_pkg::REG_PATTERN_HIGH:     pattern_word[3] <= wr.reg_data;
        mbps_pkg::REG_COMPARE_MASK:     compare_mask    <= wr.reg_data[31:0];
        mbps_pkg::REG_PATTERN_LENGTH:   pattern_length  <= wr.reg_data[5:0];
        default: begin
        end
      endcase
    end
  end

  // Unpack the pattern words into bytes.
  always_comb begin
    for (int j = 0; j < 32; j++) begin
      pat_byte[j] = pattern_word[j / 8][8 * (j % 8) +: 8];
    end
  end

  // A zero length acts as one; an over-long one is cut to the cell count.
  always_comb begin
    if (pattern_length == 6'd0) begin
      len_eff = 6'd1;
    end else if (pattern_length > CELLS_LEN) begin
      len_eff = CELLS_LEN;
    end else begin
      len_eff = pattern_length;
    end
  end

  assign accept = bytes.valid && bytes.ready;
  assign shift  = accept && !match_done;
  assign bytes.ready = has_room;

  // Window chain: cell 0 takes the new byte, each cell feeds the next.
  assign chain[0] = beat.data_byte;

  for (genvar k = 0; k < CELLS; k++) begin : g_cell
    localparam logic [5:0] POS = 6'(k);
    logic [5:0]           sel;
    mbps_pkg::cell_ctrl_t ctrl;

    // Window position k lines up with pattern byte len - 1 - k.
    assign sel          = len_eff - POS - 6'd1;
    assign ctrl.care    = (POS < len_eff) && compare_mask[sel[4:0]];
    assign ctrl.pattern = pat_byte[sel[4:0]];

    mbps_cell u_cell (
      .clk      (clk),
      .shift    (shift),
      .in_byte  (chain[k]),
      .ctrl     (ctrl),
      .out_byte (chain[k+1]),
      .hit      (hits[k])
    );
  end

  // Byte count including this beat, saturating, and the match offset.
  assign len_ext    = OFFSET_BITS'(len_eff);
  assign count_next = (bytes_seen == COUNT_MAX) ? bytes_seen : bytes_seen + OFFSET_BITS'(1);
  assign match_hit  = (count_next >= len_ext) && (&hits);
  assign offset     = (count_next == COUNT_MAX) ? COUNT_MAX : count_next - len_ext;
  assign offset_wide = {32'd0, offset};

  // A result follows a match, or the end of a region that never matched.
  assign push             = shift && (match_hit || beat.region_end);
  assign res.found        = match_hit;
  assign res.match_offset = match_hit ? offset_wide[31:0] : 32'd0;

  // Region state: cleared at the region end, frozen after a match.
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_seen <= '0;
      match_done <= 1'b0;
    end else if (accept) begin
      if (beat.region_end) begin
        bytes_seen <= '0;
        match_done <= 1'b0;
      end else if (!match_done) begin
        bytes_seen <= count_next;
        if (match_hit) begin
          match_done <= 1'b1;
        end
      end
    end
  end

  mbps_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (res),
    .has_room  (has_room),
    .result    (result)
  );

  // A region end always leaves a clean region behind it.
  `ASSERT_ALWAYS(a_region_end_clears, clk, rst,
    (accept && beat.region_end) |=> (!match_done && bytes_seen == '0))
  // A matched region stops counting and gives no second result.
  `ASSERT_ALWAYS(a_done_is_quiet, clk, rst, match_done |-> (!push && !shift))
  // The done flag is only raised by a reported match.
  `ASSERT_ALWAYS(a_done_from_match, clk, rst,
    (!match_done && !(push && match_hit)) |=> !match_done)

endmodule

// ===== tb/tb_masked_byte_pattern_scanner.sv =====
`timescale 1ns / 1ps

module tb_masked_byte_pattern_scanner;

  localparam int PATTERN_MAX = mbps_pkg::PATTERN_MAX_DEFAULT;
  localparam int OFFSET_BITS = mbps_pkg::OFFSET_BITS_DEFAULT;
  localparam int LEN_CAP = (PATTERN_MAX < mbps_pkg::PATTERN_BYTES_HELD) ?
                           PATTERN_MAX : mbps_pkg::PATTERN_BYTES_HELD;
  localparam longint unsigned COUNT_MAX = (64'd1 << OFFSET_BITS) - 64'd1;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 4;
  localparam int PHASE_BYTES = 138;

  // Register indexes that decode to nothing.
  localparam logic [2:0] REG_SPARE_6 = 3'd6;
  localparam logic [2:0] REG_SPARE_7 = 3'd7;

  typedef enum logic {ROW_CFG, ROW_BYTE} row_kind_t;

  typedef struct {
    row_kind_t         kind;
    logic [2:0]        reg_index;
    logic [63:0]       reg_data;
    logic [7:0]        data_byte;
    bit                last;
    bit                typed;
    mbps_pkg::result_t want;
  } dir_row_t;

  logic clk;
  logic rst;

  mbps_stream_if #(.payload_t(mbps_pkg::byte_beat_t)) byte_if ();
  mbps_stream_if #(.payload_t(mbps_pkg::result_t))    result_if ();
  mbps_stream_if #(.payload_t(mbps_pkg::cfg_beat_t))  cfg_if ();

  masked_byte_pattern_scanner dut (
    .clk    (clk),
    .rst    (rst),
    .bytes  (byte_if),
    .result (result_if),
    .cfg    (cfg_if)
  );

  // Scanner state as the testbench sees it.
  logic [7:0]      win_bytes [PATTERN_MAX];
  longint unsigned region_count;
  bit              region_matched;
  logic [63:0]     pat_words [4];
  logic [31:0]     care_mask;
  logic [5:0]      len_field;

  mbps_pkg::result_t expected_results [$];
  dir_row_t          dir_tab [$];
  bit                typed_row;
  mbps_pkg::result_t typed_want;
  int         errors;
  int         cycle_count;
  int         src_gap_pct;
  int         sink_hold_pct;
  int unsigned phase_items;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Length in use once zero and oversize values have been folded.
  function automatic int unsigned eff_len();
    int unsigned n;
    n = len_field;
    if (n == 0) n = 1;
    if (n > LEN_CAP) n = LEN_CAP;
    return n;
  endfunction

  function automatic logic [7:0] pat_byte(int unsigned i);
    return pat_words[i / 8][8 * (i % 8) +: 8];
  endfunction

  // Shifts one byte into the window of an unmatched region and works out the result it causes, if any.
  function automatic void predict_scan(input mbps_pkg::byte_beat_t b, output bit hit,
                                       output mbps_pkg::result_t r);
    int unsigned n;
    int k;
    bit ok;
    longint unsigned off;
    hit = 1'b0;
    r = '0;
    if (!region_matched) begin
      n = eff_len();
      for (k = PATTERN_MAX - 1; k > 0; k--) win_bytes[k] = win_bytes[k - 1];
      win_bytes[0] = b.data_byte;
      if (region_count < COUNT_MAX) region_count++;
      ok = (region_count >= n);
      for (k = 0; k < n; k++) begin
        if (care_mask[k] && win_bytes[n - 1 - k] != pat_byte(k)) ok = 1'b0;
      end
      if (ok) begin
        off = (region_count >= COUNT_MAX) ? COUNT_MAX : region_count - n;
        hit = 1'b1;
        r.found = 1'b1;
        r.match_offset = off[31:0];
        region_matched = 1'b1;
      end else if (b.region_end) begin
        hit = 1'b1;
      end
    end
    if (b.region_end) begin
      for (k = 0; k < PATTERN_MAX; k++) win_bytes[k] = 8'h00;
      region_count = 0;
      region_matched = 1'b0;
    end
  endfunction

  task automatic note_error(input string msg);
    errors++;
    $display("ERROR: %s (cycle %0d)", msg, cycle_count);
  endtask

  // Beats on every channel are taken at the rising edge.
  always @(posedge clk) begin : beat_monitor
    bit hit;
    mbps_pkg::result_t res;
    mbps_pkg::result_t got;
    mbps_pkg::result_t want;
    if (!rst) begin
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_if.payload.reg_index)
          mbps_pkg::REG_PATTERN_LOW:      pat_words[0] = cfg_if.payload.reg_data;
          mbps_pkg::REG_PATTERN_MID_LOW:  pat_words[1] = cfg_if.payload.reg_data;
          mbps_pkg::REG_PATTERN_MID_HIGH: pat_words[2] = cfg_if.payload.reg_data;
          mbps_pkg::REG_PATTERN_HIGH:     pat_words[3] = cfg_if.payload.reg_data;
          mbps_pkg::REG_COMPARE_MASK:     care_mask = cfg_if.payload.reg_data[31:0];
          mbps_pkg::REG_PATTERN_LENGTH:   len_field = cfg_if.payload.reg_data[5:0];
          default: ;
        endcase
      end
      if (byte_if.valid && byte_if.ready) begin
        predict_scan(byte_if.payload, hit, res);
        if (typed_row) expected_results.insert(expected_results.size(), typed_want);
        else if (hit) expected_results.insert(expected_results.size(), res);
      end
      if (result_if.valid && result_if.ready) begin
        got = result_if.payload;
        if (expected_results.size() == 0) begin
          note_error($sformatf("unexpected result found=%0b offset=%0d",
                               got.found, got.match_offset));
        end else begin
          want = expected_results.pop_front();
          if (got.found !== want.found)
            note_error($sformatf("found is %0b, want %0b", got.found, want.found));
          if (got.match_offset !== want.match_offset)
            note_error($sformatf("match_offset is %0d, want %0d",
                                 got.match_offset, want.match_offset));
        end
      end
    end
  end

  // The receiver holds off at random.
  always @(negedge clk) begin
    result_if.ready <= ($urandom_range(99) >= sink_hold_pct);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic dir_row_t brow(input logic [7:0] db, input bit last);
    dir_row_t r;
    r = '{kind: ROW_BYTE, reg_index: '0, reg_data: '0, data_byte: db, last: last,
          typed: 1'b0, want: '0};
    return r;
  endfunction

  function automatic dir_row_t trow(input logic [7:0] db, input bit last,
                                    input bit found, input logic [31:0] off);
    dir_row_t r;
    r = brow(db, last);
    r.typed = 1'b1;
    r.want.found = found;
    r.want.match_offset = off;
    return r;
  endfunction

  function automatic dir_row_t crow(input logic [2:0] idx, input logic [63:0] d);
    dir_row_t r;
    r = brow(8'h00, 1'b0);
    r.kind = ROW_CFG;
    r.reg_index = idx;
    r.reg_data = d;
    return r;
  endfunction

  // Appends one row to the directed table.
  function automatic void add_row(input dir_row_t r);
    dir_tab.insert(dir_tab.size(), r);
  endfunction

  // Sends one byte beat, with a random gap in front of it.
  task automatic send_byte(input logic [7:0] db, input bit last, input bit typed,
                           input mbps_pkg::result_t want);
    @(negedge clk);
    while ($urandom_range(99) < src_gap_pct) begin
      byte_if.valid <= 1'b0;
      @(negedge clk);
    end
    byte_if.valid <= 1'b1;
    byte_if.payload <= '{data_byte: db, region_end: last};
    typed_row <= typed;
    typed_want <= want;
    @(posedge clk);
    while (!byte_if.ready) @(posedge clk);
  endtask

  // Stops the byte stream until every result is back and the block is quiet.
  task automatic settle();
    @(negedge clk);
    byte_if.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [2:0] idx, input logic [63:0] d);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.payload <= '{reg_index: idx, reg_data: d};
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // Pattern bytes lean towards the extremes so that fillers hit them often.
  function automatic logic [63:0] random_pattern_word();
    logic [63:0] w;
    int i;
    for (i = 0; i < 8; i++) begin
      case ($urandom_range(3))
        0: w[8 * i +: 8] = 8'h00;
        1: w[8 * i +: 8] = 8'hFF;
        default: w[8 * i +: 8] = 8'($urandom_range(255));
      endcase
    end
    return w;
  endfunction

  function automatic logic [7:0] filler_byte();
    if ($urandom_range(1)) return pat_byte($urandom_range(LEN_CAP - 1));
    return 8'($urandom_range(255));
  endfunction

  // Writes every register; the slot steers some phases to the length extremes.
  task automatic load_config(input int unsigned slot);
    logic [63:0] d;
    logic [31:0] m;
    int unsigned len;
    case ($urandom_range(4))
      0: len = 0;
      1: len = 1;
      2: len = LEN_CAP;
      default: len = $urandom_range(2, 12);
    endcase
    case ($urandom_range(3))
      0: m = 32'hFFFF_FFFF;
      1: m = 32'h0000_0000;
      default: m = $urandom;
    endcase
    if (slot % 4 == 0) begin
      len = LEN_CAP;
      m = 32'hFFFF_FFFF;
    end else if (slot % 4 == 1) begin
      len = $urandom_range(33, 63);
      m = 32'h0000_0000;
    end
    write_cfg(mbps_pkg::REG_PATTERN_LOW, random_pattern_word());
    write_cfg(mbps_pkg::REG_PATTERN_MID_LOW, random_pattern_word());
    write_cfg(mbps_pkg::REG_PATTERN_MID_HIGH, random_pattern_word());
    write_cfg(mbps_pkg::REG_PATTERN_HIGH, random_pattern_word());
    write_cfg(mbps_pkg::REG_COMPARE_MASK, {32'($urandom), m});
    d = {32'($urandom), 32'($urandom)};
    d[5:0] = 6'(len);
    write_cfg(mbps_pkg::REG_PATTERN_LENGTH, d);
  endtask

  // Mostly regions with the pattern planted in random filler; some with one
  // byte of the plant flipped, some pure noise.
  task automatic send_region();
    logic [7:0] seq [$];
    int unsigned n, lead, tail, kind, pick, i;
    n = eff_len();
    kind = $urandom_range(9);
    if (kind >= 8) begin
      repeat ($urandom_range(1, 24)) seq.insert(seq.size(), filler_byte());
    end else begin
      lead = $urandom_range(8);
      tail = $urandom_range(5);
      repeat (lead) seq.insert(seq.size(), filler_byte());
      for (i = 0; i < n; i++)
        seq.insert(seq.size(), care_mask[i] ? pat_byte(i) : filler_byte());
      if (kind == 7) begin
        pick = $urandom_range(n - 1);
        seq[lead + pick] = ~seq[lead + pick];
      end
      repeat (tail) seq.insert(seq.size(), filler_byte());
    end
    for (i = 0; i < seq.size(); i++) send_byte(seq[i], i == seq.size() - 1, 1'b0, '0);
    phase_items += seq.size();
  endtask

  initial begin : stimulus
    int i;
    int mode;
    int c;
    int unsigned slot;
    clk = 1'b0;
    rst = 1'b1;
    errors = 0;
    cycle_count = 0;
    src_gap_pct = 23;
    sink_hold_pct = 87;
    byte_if.valid = 1'b0;
    byte_if.payload = '0;
    result_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.payload = '0;
    typed_row = 1'b0;
    typed_want = '0;
    for (i = 0; i < PATTERN_MAX; i++) win_bytes[i] = 8'h00;
    region_count = 0;
    region_matched = 1'b0;
    for (i = 0; i < 4; i++) pat_words[i] = '0;
    care_mask = '0;
    len_field = 6'd1;

    // After reset every byte is a wildcard match of length one.
    add_row(trow(8'h00, 1'b0, 1'b1, 32'd0));
    add_row(brow(8'hFF, 1'b1));
    // A match on the last byte closes the region with no not-found beat.
    add_row(trow(8'hA5, 1'b1, 1'b1, 32'd0));
    add_row(crow(REG_SPARE_6, 64'hFFFF_FFFF_FFFF_FFFF));
    add_row(crow(REG_SPARE_7, 64'hFFFF_FFFF_FFFF_FFFF));
    add_row(crow(mbps_pkg::REG_PATTERN_LOW, 64'hFFFF_FFFF_FF00_FF00));
    add_row(crow(mbps_pkg::REG_PATTERN_MID_LOW, 64'h0000_0000_0000_0000));
    add_row(crow(mbps_pkg::REG_PATTERN_MID_HIGH, 64'hFFFF_FFFF_FFFF_FFFF));
    add_row(crow(mbps_pkg::REG_PATTERN_HIGH, 64'h0000_0000_0000_0000));
    add_row(crow(mbps_pkg::REG_COMPARE_MASK, 64'hFFFF_FFFF_0000_000F));
    add_row(crow(mbps_pkg::REG_PATTERN_LENGTH, 64'hFFFF_FFFF_FFFF_FFC4));
    // Full match of four bytes, then the rest of the region is ignored.
    add_row(brow(8'h00, 1'b0));
    add_row(brow(8'hFF, 1'b0));
    add_row(brow(8'h00, 1'b0));
    add_row(trow(8'hFF, 1'b0, 1'b1, 32'd0));
    add_row(brow(8'h00, 1'b1));
    // Region shorter than the pattern: stale window bytes must not count.
    add_row(brow(8'hFF, 1'b0));
    add_row(brow(8'h00, 1'b0));
    add_row(trow(8'hFF, 1'b1, 1'b0, 32'd0));
    // Middle bytes become wildcards.
    add_row(crow(mbps_pkg::REG_COMPARE_MASK, 64'h0000_0000_0000_0009));
    add_row(brow(8'h11, 1'b0));
    add_row(brow(8'h00, 1'b0));
    add_row(brow(8'h22, 1'b0));
    add_row(brow(8'h33, 1'b0));
    add_row(brow(8'hFF, 1'b1));
    // A length of zero behaves as one.
    add_row(crow(mbps_pkg::REG_PATTERN_LENGTH, 64'h0000_0000_0000_0000));
    add_row(brow(8'h5A, 1'b0));
    add_row(brow(8'h00, 1'b1));
    add_row(trow(8'hFF, 1'b1, 1'b0, 32'd0));

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_CFG) begin
        settle();
        write_cfg(dir_tab[i].reg_index, dir_tab[i].reg_data);
      end else begin
        send_byte(dir_tab[i].data_byte, dir_tab[i].last, dir_tab[i].typed,
                  dir_tab[i].want);
      end
    end

    // Random regions under three idling patterns and four settings each.
    slot = 0;
    for (mode = 0; mode < 3; mode++) begin
      src_gap_pct = (mode == 0) ? 23 : (mode == 1) ? 87 : 0;
      sink_hold_pct = (mode == 0) ? 87 : (mode == 1) ? 23 : 0;
      for (c = 0; c < 4; c++) begin
        settle();
        load_config(slot);
        slot++;
        phase_items = 0;
        while (phase_items < PHASE_BYTES) send_region();
      end
    end

    settle();
    repeat (10) @(posedge clk);
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+sv
sv/mbps_pkg.sv
sv/mbps_stream_if.sv
sv/mbps_cell.sv
sv/mbps_out_buf.sv
sv/masked_byte_pattern_scanner.sv
tb/tb_masked_byte_pattern_scanner.sv
